@@ rtl/assert_macros.svh @@
// shared concurrent assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("%m: assertion failed");

// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
		else $error("%m: forbidden condition seen");

`endif

@@ rtl/cctab_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package cctab_pkg;

	localparam int CMD_W    = 2;
	localparam int COORD_W  = 32;
	localparam int TOTAL_W  = 31;
	localparam int INDEX_W  = 12;
	localparam int STATUS_W = 3;
	localparam int ENTRY_W  = 13;

	localparam logic [CMD_W-1:0] CMD_ACCUM = 2'd0;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

	localparam logic [STATUS_W-1:0] STAT_INSERTED = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_ACCUM    = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_DROPPED  = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_EMPTY    = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_READ     = 3'd4;
	localparam logic [STATUS_W-1:0] STAT_CLEARED  = 3'd5;

	localparam logic [31:0]        HASH_MULT = 32'h9E37_79B1;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = 31'h7FFF_FFFF;

	typedef struct packed {
		logic [CMD_W-1:0]   command;
		logic [COORD_W-1:0] coord_x;
		logic [COORD_W-1:0] coord_y;
		logic [TOTAL_W-1:0] add_count;
		logic [INDEX_W-1:0] slot_index;
	} request_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [COORD_W-1:0]  out_x;
		logic [COORD_W-1:0]  out_y;
		logic [TOTAL_W-1:0]  total_count;
		logic [ENTRY_W-1:0]  entries_used;
	} result_t;

endpackage

`default_nettype wire

@@ rtl/cctab_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cctab_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 4096
) (
	input  wire logic                             clk,
	input  wire logic                             we,
	input  wire logic [$clog2(DEPTH)-1:0]         waddr,
	input  wire logic [WIDTH-1:0]                 wdata,
	input  wire logic [$clog2(DEPTH)-1:0]         raddr,
	output logic      [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

@@ rtl/coordinate_count_merge_table.sv @@
`timescale 1ns / 1ps
`default_nettype none
// channel   | direction | ports                  | handshake
// ----------+-----------+------------------------+--------------------------------
// request   | in        | request (request_t)    | taken at edge with start && !busy
// result    | out       | result (result_t)      | valid one cycle while done high
//
// accumulate: a hash step, the reciprocal remainder when TABLE_DEPTH is not a power
//   of two, then one ram read and one check per probed slot, until a hit, an empty
//   slot or the probe limit
// read: busy in ST_READ only (registered ram read), not busy for an index beyond the table
// clear: a sweep of every table address; unused command: not busy and no result
// after reset the block sweeps the whole table with busy high
// the result strobe comes the cycle after the last busy cycle; the receiver cannot stall
`include "assert_macros.svh"

module coordinate_count_merge_table #(
	parameter int TABLE_DEPTH = 4096,
	parameter int MAX_PROBE   = 16,
	parameter int COORD_BITS  = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire cctab_pkg::request_t request,
	output logic                     done,
	output cctab_pkg::result_t       result
);

	import cctab_pkg::*;

	// derived sizes
	localparam int  AW      = $clog2(TABLE_DEPTH);
	localparam int  LIMIT   = (MAX_PROBE < TABLE_DEPTH) ? MAX_PROBE : TABLE_DEPTH;
	localparam int  PW      = $clog2(LIMIT + 1);
	localparam int  OW      = $clog2(TABLE_DEPTH + 1);
	localparam int  KW      = 2 * COORD_BITS;
	localparam int  EW      = 1 + KW + TOTAL_W;
	localparam bit  IS_POW2 = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;
	localparam logic [31:0] COORD_MASK = 32'((64'd1 << COORD_BITS) - 64'd1);
	// floor(2^32 / TABLE_DEPTH): quotient estimate is exact or one short
	localparam logic [31:0] MOD_RECIP  = 32'((64'd1 << 32) / 64'(TABLE_DEPTH));
	localparam logic [31:0] MOD_DIV    = 32'(TABLE_DEPTH);

	// sequencer, one-hot
	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_CLEAR = 7'b0000010,
		ST_HASH  = 7'b0000100,
		ST_MOD   = 7'b0001000,
		ST_PROBE = 7'b0010000,
		ST_CHECK = 7'b0100000,
		ST_READ  = 7'b1000000
	} state_t;

	state_t           state_q;
	logic [AW-1:0]    clr_addr_q;
	logic             clr_emit_q;
	logic [OW-1:0]    occ_q;
	logic [PW-1:0]    probe_cnt_q;
	logic [AW-1:0]    pos_q;
	logic [31:0]      prod_q;
	logic [31:0]      x_q;
	logic [31:0]      y_q;
	logic [TOTAL_W-1:0] cnt_q;
	logic [31:0]      mod_h_q;
	logic [31:0]      mod_qt_q;
	logic [31:0]      mod_r_q;
	logic [1:0]       mod_cnt_q;
	logic             done_q;
	result_t          res_q;

	// ram port
	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [EW-1:0]    ram_wdata;
	logic [AW-1:0]    ram_raddr;
	logic [EW-1:0]    ram_rdata;

	// request decode
	logic [31:0]      x_m;
	logic [31:0]      y_m;
	logic [31:0]      idx_wide;
	logic             idx_ok;
	logic             accept;

	// probe datapath
	logic [31:0]      hash;
	logic [31:0]      mod_a;
	logic [31:0]      mod_b;
	logic [63:0]      mod_prod;
	logic [31:0]      mod_fix;
	logic             rd_valid;
	logic [KW-1:0]    rd_key;
	logic [TOTAL_W-1:0] rd_total;
	logic [KW-1:0]    key;
	logic [31:0]      sum;
	logic [TOTAL_W-1:0] sat_sum;
	logic [AW-1:0]    pos_inc;
	logic [OW-1:0]    occ_inc;

	assign accept   = start && !busy;
	assign x_m      = request.coord_x & COORD_MASK;
	assign y_m      = request.coord_y & COORD_MASK;
	assign idx_wide = 32'(request.slot_index);
	assign idx_ok   = idx_wide < 32'(TABLE_DEPTH);

	assign hash      = prod_q ^ y_q;
	// hash mod TABLE_DEPTH over three steps on one multiplier:
	// quotient estimate, remainder, then one correcting subtract
	assign mod_a    = (mod_cnt_q == 2'd0) ? mod_h_q : mod_qt_q;
	assign mod_b    = (mod_cnt_q == 2'd0) ? MOD_RECIP : MOD_DIV;
	assign mod_prod = 64'(mod_a) * 64'(mod_b);
	assign mod_fix  = (mod_r_q >= MOD_DIV) ? mod_r_q - MOD_DIV : mod_r_q;

	assign rd_valid = ram_rdata[EW-1];
	assign rd_key   = ram_rdata[EW-2 -: KW];
	assign rd_total = ram_rdata[TOTAL_W-1:0];
	assign key      = {x_q[COORD_BITS-1:0], y_q[COORD_BITS-1:0]};

	// shared adder with saturation at the top of the total range
	assign sum     = {1'b0, rd_total} + {1'b0, cnt_q};
	assign sat_sum = sum[31] ? TOTAL_MAX : sum[TOTAL_W-1:0];

	// linear probe step, wrapping at the end of the table
	assign pos_inc = (pos_q == AW'(TABLE_DEPTH - 1)) ? '0 : pos_q + 1'b1;
	assign occ_inc = occ_q + 1'b1;

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = res_q;

	// ram control: sweep writes, probe updates, reads for probe and dump
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = {1'b1, key, cnt_q};
		ram_raddr = pos_q;
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_addr_q;
				ram_wdata = '0;
			end
			ST_IDLE: begin
				ram_raddr = idx_wide[AW-1:0];
			end
			ST_CHECK: begin
				if (!rd_valid) begin
					ram_we = 1'b1;
				end else if (rd_key == key) begin
					ram_we    = 1'b1;
					ram_wdata = {1'b1, key, sat_sum};
				end
			end
			default: begin
			end
		endcase
	end

	cctab_ram #(
		.WIDTH (EW),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			clr_emit_q  <= 1'b0;
			occ_q       <= '0;
			probe_cnt_q <= '0;
			mod_cnt_q   <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (request.command)
							CMD_ACCUM: begin
								probe_cnt_q <= '0;
								state_q     <= ST_HASH;
							end
							CMD_READ: begin
								if (idx_ok) begin
									state_q <= ST_READ;
								end else begin
									done_q <= 1'b1;
								end
							end
							CMD_CLEAR: begin
								occ_q      <= '0;
								clr_addr_q <= '0;
								clr_emit_q <= 1'b1;
								state_q    <= ST_CLEAR;
							end
							default: begin
							end
						endcase
					end
				end
				ST_CLEAR: begin
					if (clr_addr_q == AW'(TABLE_DEPTH - 1)) begin
						done_q  <= clr_emit_q;
						state_q <= ST_IDLE;
					end else begin
						clr_addr_q <= clr_addr_q + 1'b1;
					end
				end
				ST_HASH: begin
					mod_cnt_q <= '0;
					state_q   <= IS_POW2 ? ST_PROBE : ST_MOD;
				end
				ST_MOD: begin
					mod_cnt_q <= mod_cnt_q + 1'b1;
					if (mod_cnt_q == 2'd2) begin
						state_q <= ST_PROBE;
					end
				end
				ST_PROBE: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (!rd_valid) begin
						occ_q   <= occ_inc;
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else if (rd_key == key) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else if (probe_cnt_q == PW'(LIMIT - 1)) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						probe_cnt_q <= probe_cnt_q + 1'b1;
						state_q     <= ST_PROBE;
					end
				end
				ST_READ: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				x_q    <= x_m;
				y_q    <= y_m;
				cnt_q  <= request.add_count;
				// the hash multiplier, registered before the xor
				prod_q <= x_m * HASH_MULT;
				res_q.status       <= STAT_EMPTY;
				res_q.out_x        <= '0;
				res_q.out_y        <= '0;
				res_q.total_count  <= '0;
				res_q.entries_used <= ENTRY_W'(occ_q);
			end
			ST_CLEAR: begin
				res_q.status       <= STAT_CLEARED;
				res_q.out_x        <= '0;
				res_q.out_y        <= '0;
				res_q.total_count  <= '0;
				res_q.entries_used <= '0;
			end
			ST_HASH: begin
				pos_q   <= hash[AW-1:0];
				mod_h_q <= hash;
				mod_r_q <= '0;
			end
			ST_MOD: begin
				case (mod_cnt_q)
					2'd0: mod_qt_q <= mod_prod[63:32];
					2'd1: mod_r_q  <= mod_h_q - mod_prod[31:0];
					default: pos_q <= mod_fix[AW-1:0];
				endcase
			end
			ST_CHECK: begin
				res_q.out_x <= x_q;
				res_q.out_y <= y_q;
				if (!rd_valid) begin
					res_q.status       <= STAT_INSERTED;
					res_q.total_count  <= cnt_q;
					res_q.entries_used <= ENTRY_W'(occ_inc);
				end else if (rd_key == key) begin
					res_q.status       <= STAT_ACCUM;
					res_q.total_count  <= sat_sum;
					res_q.entries_used <= ENTRY_W'(occ_q);
				end else begin
					res_q.status       <= STAT_DROPPED;
					res_q.total_count  <= '0;
					res_q.entries_used <= ENTRY_W'(occ_q);
					pos_q              <= pos_inc;
				end
			end
			ST_READ: begin
				res_q.entries_used <= ENTRY_W'(occ_q);
				if (rd_valid) begin
					res_q.status      <= STAT_READ;
					res_q.out_x       <= 32'(rd_key[KW-1 -: COORD_BITS]);
					res_q.out_y       <= 32'(rd_key[COORD_BITS-1:0]);
					res_q.total_count <= rd_total;
				end else begin
					res_q.status      <= STAT_EMPTY;
					res_q.out_x       <= '0;
					res_q.out_y       <= '0;
					res_q.total_count <= '0;
				end
			end
			default: begin
			end
		endcase
	end

	// occupancy never passes the table size
	`ASSERT_CLK(a_occ_bound, clk, arst_n, occ_q <= OW'(TABLE_DEPTH))
	// probe counter stays inside the probe limit
	`ASSERT_CLK(a_probe_bound, clk, arst_n, probe_cnt_q < PW'(LIMIT))
	// an insert result always follows a one-step rise in occupancy
	`ASSERT_CLK(a_insert_occ, clk, arst_n,
		(done_q && res_q.status == STAT_INSERTED) |-> (occ_q == $past(occ_q) + 1'b1))
	// the table is never written while the block looks idle
	`ASSERT_NEVER(a_idle_write, clk, arst_n, ram_we && !busy)

endmodule

`default_nettype wire
